FILE: hdl/assert_macros.svh
// Assertion helpers shared by the registry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RIR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rir_pkg.sv
`timescale 1ns / 1ps

package rir_pkg;

  localparam int SLOTS      = 4;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int CNT_OUT_W  = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [1:0] {
    MODE_ACQUIRE  = 2'd0,
    MODE_REL_KEY  = 2'd1,
    MODE_REL_SLOT = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_FREED    = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_INVALID  = 3'd6,
    ST_OVERFLOW = 3'd7
  } status_t;

  typedef struct packed {
    logic             go;
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic             any_hit;
  } req_t;

  typedef struct packed {
    logic hit;
    logic free;
  } chain_t;

  typedef struct packed {
    logic                  touched;
    status_t               status;
    logic [COUNT_BITS-1:0] count;
    logic                  occ;
  } resp_t;

endpackage

FILE: hdl/refcounted_id_registry.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid in_ready    in_mode in_group_key in_slot_index
// out      out_valid out_ready  out_status out_slot_used out_count_after out_registry_empty
//
// Every slot cell compares its key in the cycle of the request transfer; the lowest
// match and lowest free slot ripple along the cell chain.
// The result lands in an output register in the cycle after the request transfer; a new
// request is taken when that register is empty or being drained in the same cycle.
// Back to back, one request per cycle while out_ready is high.
// Reset clears all slots (free, count zero) and the output valid flag.
// A stalled output holds the request channel off until the result transfer.

`include "assert_macros.svh"

module refcounted_id_registry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_group_key,
  input  logic [1:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [1:0]  out_slot_used,
  output logic [15:0] out_count_after,
  output logic        out_registry_empty
);

  rir_pkg::req_t                  req;
  rir_pkg::chain_t                chain [rir_pkg::SLOTS+1];
  rir_pkg::resp_t                 resp  [rir_pkg::SLOTS];
  logic [rir_pkg::SLOTS-1:0]      pick;
  logic [rir_pkg::SLOTS-1:0]      touched_vec;
  logic                           go, any_touch, empty_nxt, key_zero;
  logic [2:0]                     st_or, st_nxt;
  logic [1:0]                     slot_or;
  logic [rir_pkg::COUNT_BITS-1:0] cnt_or;

  logic                            out_valid_r;
  logic [2:0]                      status_r;
  logic [1:0]                      slot_r;
  logic [rir_pkg::CNT_OUT_W-1:0]   count_r;
  logic                            empty_r;

  assign in_ready = !out_valid_r || out_ready;
  assign go       = in_valid && in_ready;
  assign key_zero = ~|in_group_key;

  assign req.go      = go;
  assign req.mode    = rir_pkg::mode_t'(in_mode);
  assign req.key     = in_group_key;
  assign req.any_hit = chain[rir_pkg::SLOTS].hit;
  assign chain[0]    = '0;

  for (genvar i = 0; i < rir_pkg::SLOTS; i++) begin : g_cell
    assign pick[i]        = (32'(in_slot_index) == 32'(i));
    assign touched_vec[i] = resp[i].touched;
    rir_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req),
      .pick     (pick[i]),
      .chain_in (chain[i]),
      .chain_out(chain[i+1]),
      .resp     (resp[i])
    );
  end

  always_comb begin
    any_touch = 1'b0;
    st_or     = '0;
    slot_or   = '0;
    cnt_or    = '0;
    empty_nxt = 1'b1;
    for (int i = 0; i < rir_pkg::SLOTS; i++) begin
      if (resp[i].touched) begin
        any_touch = 1'b1;
        st_or     = st_or | resp[i].status;
        slot_or   = slot_or | 2'(i);
        cnt_or    = cnt_or | resp[i].count;
      end
      empty_nxt = empty_nxt & !resp[i].occ;
    end
  end

  always_comb begin
    priority if (any_touch) begin
      st_nxt = st_or;
    end else if (((req.mode == rir_pkg::MODE_ACQUIRE) || (req.mode == rir_pkg::MODE_REL_KEY))
                 && key_zero) begin
      st_nxt = rir_pkg::ST_INVALID;
    end else if (req.mode == rir_pkg::MODE_ACQUIRE) begin
      st_nxt = rir_pkg::ST_FULL;
    end else begin
      st_nxt = rir_pkg::ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status_r <= st_nxt;
      slot_r   <= slot_or;
      count_r  <= rir_pkg::CNT_OUT_W'(cnt_or);
      empty_r  <= empty_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_used      = slot_r;
  assign out_count_after    = count_r;
  assign out_registry_empty = empty_r;

  `RIR_ASSERT(a_single_slot, $onehot0(touched_vec), "request touched more than one slot")
  `RIR_ASSERT(a_stall_blocks, (out_valid_r && !out_ready) |-> !in_ready,
              "request taken while result stalled")
  `RIR_ASSERT(a_alloc_nonempty,
              (out_valid_r && (status_r == rir_pkg::ST_ALLOC)) |-> !empty_r,
              "allocation reported an empty registry")
  `RIR_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

FILE: hdl/rir_cell.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rir_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  rir_pkg::req_t   req,
  input  logic            pick,
  input  rir_pkg::chain_t chain_in,
  output rir_pkg::chain_t chain_out,
  output rir_pkg::resp_t  resp
);

  logic [rir_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [rir_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                           occ, key_ok, hit_here, first_hit;
  logic                           claim, bump, drop;

  always_comb begin
    occ       = |key_r;
    key_ok    = |req.key;
    hit_here  = key_ok && (key_r == req.key);
    first_hit = hit_here && !chain_in.hit;
    chain_out.hit  = chain_in.hit | hit_here;
    chain_out.free = chain_in.free | !occ;
    claim = (req.mode == rir_pkg::MODE_ACQUIRE) && key_ok && !req.any_hit
            && !occ && !chain_in.free;
    bump  = (req.mode == rir_pkg::MODE_ACQUIRE) && first_hit;
    drop  = ((req.mode == rir_pkg::MODE_REL_KEY) && first_hit)
            || ((req.mode == rir_pkg::MODE_REL_SLOT) && pick && occ);
  end

  always_comb begin
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    resp.touched = 1'b1;
    resp.status  = rir_pkg::ST_NOTFOUND;
    priority if (bump) begin
      if (cnt_r == rir_pkg::CNT_MAX) begin
        resp.status = rir_pkg::ST_OVERFLOW;
      end else begin
        cnt_nxt     = cnt_r + rir_pkg::CNT_ONE;
        resp.status = rir_pkg::ST_FOUND;
      end
    end else if (claim) begin
      key_nxt     = req.key;
      cnt_nxt     = rir_pkg::CNT_ONE;
      resp.status = rir_pkg::ST_ALLOC;
    end else if (drop) begin
      if (cnt_r <= rir_pkg::CNT_ONE) begin
        key_nxt     = '0;
        cnt_nxt     = '0;
        resp.status = rir_pkg::ST_FREED;
      end else begin
        cnt_nxt     = cnt_r - rir_pkg::CNT_ONE;
        resp.status = rir_pkg::ST_RELEASED;
      end
    end else begin
      resp.touched = 1'b0;
    end
    resp.count = cnt_nxt;
    resp.occ   = |key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      cnt_r <= '0;
    end else if (req.go) begin
      key_r <= key_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `RIR_ASSERT(a_one_action, $onehot0({bump, claim, drop}), "cell takes more than one action")
  `RIR_ASSERT(a_free_zero, (key_r == '0) |-> (cnt_r == '0), "free slot holds a count")
  `RIR_ASSERT(a_hold_idle, !$past(req.go) |-> ($stable(key_r) && $stable(cnt_r)),
              "slot changed without a transfer")

endmodule
